@@ rtl/core/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// Turtle line interpreter package
// Shared types, symbol codes, register indexes and the sine table generator.
// ----------------------------------------------------------------------------
package tli_pkg;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_TURN_ANGLE    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_LENGTH   = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_X       = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_Y       = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_HEADING = 3'd4;

   localparam logic [7:0] SYM_DRAW_F = 8'h46;
   localparam logic [7:0] SYM_DRAW_A = 8'h41;
   localparam logic [7:0] SYM_DRAW_B = 8'h42;
   localparam logic [7:0] SYM_PLUS   = 8'h2B;
   localparam logic [7:0] SYM_MINUS  = 8'h2D;
   localparam logic [7:0] SYM_PUSH   = 8'h5B;
   localparam logic [7:0] SYM_POP    = 8'h5D;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_DRAW,
      OP_TURN_POS,
      OP_TURN_NEG,
      OP_PUSH,
      OP_POP
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      logic        last;
   } op_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last_symbol;
   } req_type;

   typedef struct packed {
      logic signed [15:0] seg_x0;
      logic signed [15:0] seg_y0;
      logic signed [15:0] seg_x1;
      logic signed [15:0] seg_y1;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        turn_angle;
      logic [15:0]        step_length;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic [15:0]        start_heading;
   } cfg_type;

   typedef struct packed {
      logic pop_busy;
      logic delta_ready;
   } bk_status_type;

   // Quarter-wave sine entry in Q1.14 for index idx of 2**bits steps, built
   // from a Q30 Taylor series.
   function automatic logic [14:0] sine_entry(input int idx, input int bits);
      longint unsigned theta;
      longint unsigned t2;
      longint unsigned term;
      longint          sum;
      longint          r;
      theta = (HALF_PI_Q30 * 64'(idx)) >> bits;
      t2 = (theta * theta) >> 30;
      term = theta;
      sum = longint'(theta);
      for (int k = 1; k <= 12; k++) begin
         term = (term * t2) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if ((k & 1) != 0) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum * 64'sd16384 + 64'sd536870912) >>> 30;
      if (r > 64'sd16384) r = 64'sd16384;
      return r[14:0];
   endfunction

endpackage

@@ rtl/core/tli_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tli_front.sv @@
// ----------------------------------------------------------------------------
// Turtle line interpreter front end
// Accepts symbols, decodes them into operations and queues them for the back end.
// ----------------------------------------------------------------------------
module tli_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tli_pkg::req_type req_data,
   output logic             op_valid,
   input  logic             op_ready,
   output tli_pkg::op_type  op_data
);

   tli_pkg::op_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   tli_pkg::op_type decoded;
   logic            push;
   logic            pop;

   always_comb begin
      decoded.last = req_data.last_symbol;
      unique case (req_data.symbol)
         tli_pkg::SYM_DRAW_F, tli_pkg::SYM_DRAW_A, tli_pkg::SYM_DRAW_B:
            decoded.code = tli_pkg::OP_DRAW;
         tli_pkg::SYM_PLUS:  decoded.code = tli_pkg::OP_TURN_POS;
         tli_pkg::SYM_MINUS: decoded.code = tli_pkg::OP_TURN_NEG;
         tli_pkg::SYM_PUSH:  decoded.code = tli_pkg::OP_PUSH;
         tli_pkg::SYM_POP:   decoded.code = tli_pkg::OP_POP;
         default:            decoded.code = tli_pkg::OP_NOP;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign op_valid  = (count_ff != 2'd0);
   assign op_data   = entry_ff[rd_ptr_ff];
   assign push      = req_valid & req_ready;
   assign pop       = op_valid & op_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ rtl/core/tli_back.sv @@
// ----------------------------------------------------------------------------
// Turtle line interpreter back end
// Holds the pen pose, the sine and step pipeline, the pose stack and the result register.
// ----------------------------------------------------------------------------
module tli_back #(
   parameter int STACK_DEPTH     = 64,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tli_pkg::cfg_type                    cfg,
   input  logic                                cfg_wr,
   input  logic                                op_valid,
   output logic                                op_ready,
   input  tli_pkg::op_type                     op_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tli_pkg::rsp_type                    rsp_data,
   output tli_pkg::bk_status_type              status,
   output logic [$clog2(STACK_DEPTH+1)-1:0]    level
);

   localparam int LW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int QN = 1 << SINE_TABLE_BITS;
   localparam int B  = SINE_TABLE_BITS;

   typedef logic [14:0] rom_type [QN+1];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i <= QN; i++) begin
         r[i] = tli_pkg::sine_entry(i, B);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   function automatic logic signed [15:0] sine_of(input logic [15:0] h);
      logic [B:0]  idx;
      logic [14:0] mag;
      idx = {1'b0, h[13 -: B]};
      if (h[14]) begin
         idx = (B+1)'(QN) - idx;
      end
      mag = SINE_ROM[idx];
      return h[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   function automatic logic signed [15:0] whole(input logic signed [23:0] v);
      logic signed [15:0] w;
      w = v[23:8];
      if (v[23] && (v[7:0] != 8'd0)) begin
         w = w + 16'sd1;
      end
      return w;
   endfunction

   function automatic logic signed [23:0] advance(input logic signed [23:0] p,
                                                   input logic signed [32:0] prod);
      logic signed [32:0] rnd;
      logic signed [24:0] sum;
      rnd = prod + 33'sd8192;
      sum = {p[23], p} + {{6{rnd[32]}}, rnd[32:14]};
      if (sum > 25'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (sum < -25'sd8388608) begin
         return 24'sh800000;
      end
      return sum[23:0];
   endfunction

   logic signed [23:0] pen_x_ff, pen_x_in;
   logic signed [23:0] pen_y_ff, pen_y_in;
   logic [15:0]        heading_ff, heading_in;
   logic [LW-1:0]      level_ff, level_in;
   logic [1:0]         stale_ff, stale_in;
   logic               pop_busy_ff, pop_busy_in;
   logic signed [15:0] cos_ff, sin_ff;
   logic signed [32:0] prod_x_ff, prod_y_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tli_pkg::rsp_type   rsp_ff, rsp_in;
   logic               mem_we;
   logic [63:0]        mem_wdata;
   logic [63:0]        mem_rdata;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic signed [23:0] nx, ny;
   logic               done;

   assign wr_addr   = level_ff[AW-1:0];
   assign rd_addr   = AW'(level_ff - LW'(1));
   assign mem_wdata = {pen_x_ff, pen_y_ff, heading_ff};
   assign nx        = advance(pen_x_ff, prod_x_ff);
   assign ny        = advance(pen_y_ff, prod_y_ff);

   tli_ram #(
      .WIDTH (64),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      heading_in   = heading_ff;
      level_in     = level_ff;
      stale_in     = (stale_ff != 2'd0) ? stale_ff - 2'd1 : 2'd0;
      pop_busy_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      done         = 1'b0;
      if (pop_busy_ff) begin
         pen_x_in   = mem_rdata[63:40];
         pen_y_in   = mem_rdata[39:16];
         heading_in = mem_rdata[15:0];
         level_in   = level_ff - LW'(1);
         stale_in   = 2'd2;
         done       = 1'b1;
      end else if (op_valid) begin
         unique case (op_data.code)
            tli_pkg::OP_DRAW: begin
               if ((stale_ff == 2'd0) && (!rsp_valid_ff || rsp_ready)) begin
                  rsp_in.seg_x0 = whole(pen_x_ff);
                  rsp_in.seg_y0 = whole(pen_y_ff);
                  rsp_in.seg_x1 = whole(nx);
                  rsp_in.seg_y1 = whole(ny);
                  rsp_valid_in  = 1'b1;
                  pen_x_in      = nx;
                  pen_y_in      = ny;
                  done          = 1'b1;
               end
            end
            tli_pkg::OP_TURN_POS: begin
               heading_in = heading_ff + cfg.turn_angle;
               stale_in   = 2'd2;
               done       = 1'b1;
            end
            tli_pkg::OP_TURN_NEG: begin
               heading_in = heading_ff - cfg.turn_angle;
               stale_in   = 2'd2;
               done       = 1'b1;
            end
            tli_pkg::OP_PUSH: begin
               if (level_ff < LW'(STACK_DEPTH)) begin
                  mem_we   = 1'b1;
                  level_in = level_ff + LW'(1);
               end
               done = 1'b1;
            end
            tli_pkg::OP_POP: begin
               if (level_ff != LW'(0)) begin
                  pop_busy_in = 1'b1;
               end else begin
                  done = 1'b1;
               end
            end
            default: done = 1'b1;
         endcase
      end
      if (done && op_data.last) begin
         pen_x_in   = {cfg.start_x, 8'd0};
         pen_y_in   = {cfg.start_y, 8'd0};
         heading_in = cfg.start_heading;
         level_in   = LW'(0);
         stale_in   = 2'd2;
      end
      if (cfg_wr) begin
         stale_in = 2'd2;
      end
   end

   assign op_ready = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= 24'sd81920;
         pen_y_ff     <= 24'sd107520;
         heading_ff   <= 16'd49152;
         level_ff     <= LW'(0);
         stale_ff     <= 2'd2;
         pop_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         heading_ff   <= heading_in;
         level_ff     <= level_in;
         stale_ff     <= stale_in;
         pop_busy_ff  <= pop_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff    <= rsp_in;
      cos_ff    <= sine_of(heading_ff + 16'd16384);
      sin_ff    <= sine_of(heading_ff);
      prod_x_ff <= $signed({1'b0, cfg.step_length}) * cos_ff;
      prod_y_ff <= $signed({1'b0, cfg.step_length}) * sin_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;
   assign status.pop_busy    = pop_busy_ff;
   assign status.delta_ready = (stale_ff == 2'd0);
   assign level              = level_ff;

endmodule

@@ rtl/core/turtle_line_interpreter_top.sv @@
// ----------------------------------------------------------------------------
// Turtle line interpreter top level
// Control registers, symbol front end and pose back end.
// ----------------------------------------------------------------------------
// The block takes one symbol per cycle while its two-entry queue has room and
// returns one segment for each draw symbol; the symbol is registered in the
// queue and the segment in the result register. A pop of a stacked pose waits
// in a busy state because the pose stack is a RAM with a registered read. A draw
// symbol that follows a turn, a pop, a last symbol or a register write waits
// until the two-stage sine lookup and step multiply pipeline has caught up with
// the new heading, and while the previous segment is held by the receiver.
module turtle_line_interpreter_top #(
   parameter int STACK_DEPTH     = 64,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tli_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tli_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [tli_pkg::CSR_ADDR_BITS-1:0]    csr_index,
   input  logic [tli_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   tli_pkg::cfg_type              cfg_ff;
   tli_pkg::op_type               q_data;
   logic                          q_valid;
   logic                          q_ready;
   tli_pkg::bk_status_type        st;
   logic [$clog2(STACK_DEPTH+1)-1:0] level;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_angle    <= 16'd4551;
         cfg_ff.step_length   <= 16'd512;
         cfg_ff.start_x       <= 16'sd320;
         cfg_ff.start_y       <= 16'sd420;
         cfg_ff.start_heading <= 16'd49152;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tli_pkg::CSR_TURN_ANGLE:    cfg_ff.turn_angle    <= csr_wdata;
            tli_pkg::CSR_STEP_LENGTH:   cfg_ff.step_length   <= csr_wdata;
            tli_pkg::CSR_START_X:       cfg_ff.start_x       <= csr_wdata;
            tli_pkg::CSR_START_Y:       cfg_ff.start_y       <= csr_wdata;
            tli_pkg::CSR_START_HEADING: cfg_ff.start_heading <= csr_wdata;
            default: ;
         endcase
      end
   end

   tli_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .op_valid  (q_valid),
      .op_ready  (q_ready),
      .op_data   (q_data)
   );

   tli_back #(
      .STACK_DEPTH     (STACK_DEPTH),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_wr    (csr_wr_en),
      .op_valid  (q_valid),
      .op_ready  (q_ready),
      .op_data   (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .status    (st),
      .level     (level)
   );

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
      else $error("pose stack level beyond depth");

   a_cfg_restarts_delta: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !st.delta_ready)
      else $error("step pipeline not restarted after register write");

   a_queue_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_valid)
      else $error("accepted symbol missing from queue");

   a_pop_one_wait: assert property (@(posedge clock) disable iff (reset)
      st.pop_busy |=> !st.pop_busy)
      else $error("pop wait longer than one cycle");

endmodule
